// File: rtl/iss_pkg.sv
// shared types, codes and the saturating add helper of the integer stream summarizer
package iss_pkg;

   localparam logic [3:0] OP_MIN    = 4'd0;
   localparam logic [3:0] OP_MAX    = 4'd1;
   localparam logic [3:0] OP_RANGE  = 4'd2;
   localparam logic [3:0] OP_SUM    = 4'd3;
   localparam logic [3:0] OP_PROD   = 4'd4;
   localparam logic [3:0] OP_ANY    = 4'd5;
   localparam logic [3:0] OP_ALL    = 4'd6;
   localparam logic [3:0] OP_SHIFT2 = 4'd7;
   localparam logic [3:0] OP_XX2    = 4'd8;

   localparam logic [1:0] REG_OPERATION = 2'd0;
   localparam logic [1:0] REG_DROP      = 2'd1;
   localparam logic [1:0] REG_SHIFT     = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_BITS  = 2;

   localparam logic [31:0] MISSING_CODE = 32'h8000_0000;
   localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic signed [31:0] value;
      logic               value_valid;
      logic               last;
      logic               implicit_zero;
   } req_type;

   typedef struct packed {
      logic signed [63:0] result_low;
      logic signed [63:0] result_high;
      logic               result_missing;
      logic [31:0]        missing_seen;
      logic               empty_warning;
      logic               overflow;
      logic               stopped_early;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic               elem;
      logic               missing;
      logic               last;
      logic               zero;
   } entry_type;

   typedef struct packed {
      logic [3:0]         operation;
      logic               drop_missing;
      logic signed [31:0] shift_value;
   } cfg_type;

   // bit 64 flags saturation, bits 63:0 the clamped sum
   function automatic logic [64:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [63:0] s;
      logic               ovf;
      s = a + b;
      ovf = (a[63] == b[63]) && (s[63] != a[63]);
      if (ovf) begin
         return {1'b1, (a[63] ? INT64_MIN : INT64_MAX)};
      end
      return {1'b0, s};
   endfunction

endpackage

// File: rtl/iss_front.sv
// front end: accepts input words and classifies them into queue entries
module iss_front import iss_pkg::*; (
   input  logic      req_valid,
   input  req_type   req_word,
   input  logic      queue_full,
   output logic      req_stall,
   output logic      push,
   output entry_type entry
);

   assign req_stall     = queue_full;
   assign push          = req_valid && !queue_full;
   assign entry.x       = req_word.value;
   assign entry.elem    = req_word.value_valid;
   assign entry.missing = (req_word.value == MISSING_CODE);
   assign entry.last    = req_word.last;
   assign entry.zero    = req_word.last && req_word.implicit_zero;

endmodule

// File: rtl/iss_queue.sv
// short queue between the front and back ends
module iss_queue import iss_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      empty,
   output logic      full
);

   entry_type             mem [QUEUE_DEPTH];
   logic [QUEUE_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_BITS:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (QUEUE_BITS+1)'(QUEUE_DEPTH));
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_BITS'(push);
      rd_ptr_in = rd_ptr_ff + QUEUE_BITS'(pop);
      count_in  = count_ff + (QUEUE_BITS+1)'(push) - (QUEUE_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/iss_back.sv
// back end: term stage, accumulators and result register
module iss_back import iss_pkg::*; #(
   parameter int COUNT_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      op_load,
   input  entry_type head,
   input  logic      empty,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_word
);

   logic                  s1_valid_ff, s1_valid_in;
   entry_type             s1_ff;
   logic [63:0]           sq8_ff;
   logic [65:0]           sq7_ff;
   logic signed [32:0]    diff;
   logic [32:0]           diff_mag;

   logic                  phase_ff, phase_in;
   logic [63:0]           pl_ff, ph_ff;
   logic                  neg_ff, pzero_ff;

   logic signed [63:0]    low_ff, low_in, high_ff, high_in;
   logic                  have_ff, have_in, miss_ff, miss_in;
   logic                  stop_ff, stop_in, ovf_ff, ovf_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  need_mul, out_free, consume;
   logic [63:0]           ma;
   logic [31:0]           mb;
   logic [95:0]           prod_full;
   logic [64:0]           sa, sb;
   logic signed [63:0]    term7, low_reload;
   logic                  known_op, res_missing, warn;
   logic [63:0]           cnt_ext;

   assign known_op   = (cfg.operation <= OP_XX2);
   assign low_reload = (cfg.operation == OP_PROD || cfg.operation == OP_ALL) ? 64'sd1 : 64'sd0;

   assign need_mul = s1_valid_ff && (cfg.operation == OP_PROD) && s1_ff.elem
                     && !s1_ff.missing && !stop_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign consume  = s1_valid_ff && !(need_mul && !phase_ff) && (!s1_ff.last || out_free);
   assign pop      = !empty && (!s1_valid_ff || consume);

   assign diff     = 33'(head.x) - 33'(cfg.shift_value);
   assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

   assign ma = low_ff[63] ? 64'(-low_ff) : 64'(low_ff);
   assign mb = s1_ff.x[31] ? 32'(-s1_ff.x) : 32'(s1_ff.x);
   assign prod_full = {ph_ff, 32'b0} + {32'b0, pl_ff};

   always_comb begin
      phase_in = phase_ff;
      if (need_mul && !phase_ff) begin
         phase_in = 1'b1;
      end else if (consume) begin
         phase_in = 1'b0;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pop) begin
         s1_valid_in = 1'b1;
      end else if (consume) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      have_in = have_ff;
      miss_in = miss_ff;
      stop_in = stop_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      sa      = '0;
      sb      = '0;
      term7   = '0;
      res_missing  = 1'b0;
      warn         = 1'b0;
      cnt_ext      = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      if (consume) begin
         // element fold
         if (s1_ff.elem && !stop_ff && known_op) begin
            if (s1_ff.missing) begin
               if (cfg.operation == OP_ANY || cfg.operation == OP_ALL) begin
                  if (!cfg.drop_missing) begin
                     miss_in = 1'b1;
                  end
                  if (cnt_ff != '1) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end else if (cfg.drop_missing) begin
                  if (cnt_ff != '1) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end else begin
                  miss_in = 1'b1;
                  stop_in = 1'b1;
               end
            end else begin
               unique case (cfg.operation)
                  OP_MIN: begin
                     if (!have_ff || 64'(s1_ff.x) < low_ff) begin
                        low_in = 64'(s1_ff.x);
                     end
                     have_in = 1'b1;
                  end
                  OP_MAX: begin
                     if (!have_ff || 64'(s1_ff.x) > low_ff) begin
                        low_in = 64'(s1_ff.x);
                     end
                     have_in = 1'b1;
                  end
                  OP_RANGE: begin
                     if (!have_ff) begin
                        low_in  = 64'(s1_ff.x);
                        high_in = 64'(s1_ff.x);
                     end else begin
                        if (64'(s1_ff.x) < low_ff) begin
                           low_in = 64'(s1_ff.x);
                        end
                        if (64'(s1_ff.x) > high_ff) begin
                           high_in = 64'(s1_ff.x);
                        end
                     end
                     have_in = 1'b1;
                  end
                  OP_SUM: begin
                     sa     = sat_add(low_ff, 64'(s1_ff.x));
                     low_in = sa[63:0];
                     ovf_in = ovf_ff | sa[64];
                  end
                  OP_PROD: begin
                     if (pzero_ff) begin
                        low_in = '0;
                     end else if (prod_full > (neg_ff ? 96'h8000_0000_0000_0000
                                                      : 96'h7FFF_FFFF_FFFF_FFFF)) begin
                        low_in = neg_ff ? INT64_MIN : INT64_MAX;
                        ovf_in = 1'b1;
                     end else begin
                        low_in = neg_ff ? 64'(-prod_full[63:0]) : 64'(prod_full[63:0]);
                     end
                  end
                  OP_ANY: begin
                     if (s1_ff.x != '0) begin
                        low_in  = 64'sd1;
                        miss_in = 1'b0;
                        stop_in = 1'b1;
                     end
                  end
                  OP_ALL: begin
                     if (s1_ff.x == '0) begin
                        low_in  = 64'sd0;
                        miss_in = 1'b0;
                        stop_in = 1'b1;
                     end
                  end
                  OP_SHIFT2: begin
                     if (sq7_ff > 66'(INT64_MAX)) begin
                        term7  = INT64_MAX;
                        ovf_in = 1'b1;
                     end else begin
                        term7 = sq7_ff[63:0];
                     end
                     sa     = sat_add(low_ff, term7);
                     low_in = sa[63:0];
                     ovf_in = ovf_in | sa[64];
                  end
                  default: begin
                     sa      = sat_add(low_ff, 64'(s1_ff.x));
                     sb      = sat_add(high_ff, sq8_ff);
                     low_in  = sa[63:0];
                     high_in = sb[63:0];
                     ovf_in  = ovf_ff | sa[64] | sb[64];
                  end
               endcase
            end
         end

         // implicit zero on the closing word
         if (s1_ff.zero && !stop_in && known_op && cfg.operation != OP_SHIFT2) begin
            priority if (cfg.operation == OP_MIN) begin
               if (!have_in || low_in > 64'sd0) begin
                  low_in = '0;
               end
               have_in = 1'b1;
            end else if (cfg.operation == OP_MAX) begin
               if (!have_in || low_in < 64'sd0) begin
                  low_in = '0;
               end
               have_in = 1'b1;
            end else if (cfg.operation == OP_RANGE) begin
               if (!have_in || low_in > 64'sd0) begin
                  low_in = '0;
               end
               if (!have_in || high_in < 64'sd0) begin
                  high_in = '0;
               end
               have_in = 1'b1;
            end else if (cfg.operation == OP_PROD) begin
               low_in = '0;
            end else if (cfg.operation == OP_ALL) begin
               low_in  = '0;
               miss_in = 1'b0;
               stop_in = 1'b1;
            end else begin
               low_in = low_in;
            end
         end

         if (s1_ff.last) begin
            res_missing = miss_in || !known_op;
            if (known_op && cfg.operation <= OP_RANGE && !miss_in && !have_in) begin
               res_missing = 1'b1;
               warn        = 1'b1;
            end
            cnt_ext = 64'(cnt_in);
            rsp_in.result_low  = res_missing ? 64'sd0 : low_in;
            rsp_in.result_high = (!res_missing && (cfg.operation == OP_RANGE
                                  || cfg.operation == OP_XX2)) ? high_in : 64'sd0;
            rsp_in.result_missing = res_missing;
            rsp_in.missing_seen   = (cnt_ext > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                        : cnt_ext[31:0];
            rsp_in.empty_warning  = warn;
            rsp_in.overflow       = ovf_in;
            rsp_in.stopped_early  = stop_in;
            rsp_valid_in = 1'b1;
         end
      end

      if (op_load || (consume && s1_ff.last)) begin
         low_in  = low_reload;
         high_in = '0;
         have_in = 1'b0;
         miss_in = 1'b0;
         stop_in = 1'b0;
         ovf_in  = 1'b0;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ff  <= head;
         sq8_ff <= 64'(head.x * head.x);
         sq7_ff <= diff_mag * diff_mag;
      end
      if (need_mul && !phase_ff) begin
         pl_ff    <= 64'(ma[31:0]) * 64'(mb);
         ph_ff    <= 64'(ma[63:32]) * 64'(mb);
         neg_ff   <= low_ff[63] ^ s1_ff.x[31];
         pzero_ff <= (ma == '0) || (mb == '0);
      end
      low_ff  <= low_in;
      high_ff <= high_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         have_ff      <= 1'b0;
         miss_ff      <= 1'b0;
         stop_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         phase_ff     <= phase_in;
         have_ff      <= have_in;
         miss_ff      <= miss_in;
         stop_ff      <= stop_in;
         ovf_ff       <= ovf_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_phase_needs_word: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> s1_valid_ff)
      else $error("multiply phase without a word in the term stage");

   a_close_clears_count: assert property (@(posedge clock) disable iff (reset)
      (consume && s1_ff.last) |=> (cnt_ff == '0 && !stop_ff && !ovf_ff))
      else $error("run state not reloaded after a result");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("pending result lost");

endmodule

// File: rtl/integer_stream_summarizer.sv
// top level of the integer stream summarizer: registers, front end, queue and back end
//
//  channel   direction  handshake            content
//  req_      in         req_valid/req_stall  value, value_valid, last, implicit_zero
//  rsp_      out        rsp_valid/rsp_stall  one result per run
//  csr_      in         csr_write            operation, drop_missing, shift_value
//
//  one word per cycle unless a full queue or a held result stalls it; product mode
//  holds each element for the split 64x32 multiply feeding back into the accumulator
//  a closing word passes the queue and the term stage before its result is registered
//  reset is synchronous and clears all control state; no clearing pass
//  the queue absorbs a stalled result while input keeps flowing until full
module integer_stream_summarizer import iss_pkg::*; #(
   parameter int COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_word,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type   cfg_ff;
   logic      op_load_ff, op_load_in, push, pop, empty, full;
   entry_type entry, head;

   // run state reloads once the new operation is in place
   assign op_load_in = csr_write && (csr_index == REG_OPERATION);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff     <= '0;
         op_load_ff <= 1'b1;
      end else begin
         op_load_ff <= op_load_in;
         if (csr_write) begin
            unique case (csr_index)
               REG_OPERATION: cfg_ff.operation    <= csr_wdata[3:0];
               REG_DROP:      cfg_ff.drop_missing <= csr_wdata[0];
               REG_SHIFT:     cfg_ff.shift_value  <= csr_wdata;
               default:       cfg_ff              <= cfg_ff;
            endcase
         end
      end
   end

   iss_front u_front (
      .req_valid  (req_valid),
      .req_word   (req_word),
      .queue_full (full),
      .req_stall  (req_stall),
      .push       (push),
      .entry      (entry)
   );

   iss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   iss_back #(.COUNT_BITS(COUNT_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .op_load   (op_load_ff),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
